[design/utf16_to_utf8_transcoder_macros.svh]
// assertion macros shared by the checker
`ifndef UTF16_TO_UTF8_TRANSCODER_MACROS_SVH
`define UTF16_TO_UTF8_TRANSCODER_MACROS_SVH

// clocked implication check, disabled while in reset
`define U16U8_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// check that a stalled valid word does not move
`define U16U8_ASSERT_HOLD(lbl, vld, stl, sig, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (vld && stl) |=> (vld && $stable(sig))) else $error(msg);

`endif

[design/u16u8_pkg.sv]
`default_nettype none
package u16u8_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int MAX_BYTES   = 6;

    localparam logic [15:0] HIGH_SURR_BASE = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE  = 16'hDC00;
    localparam logic [20:0] SUPP_BASE      = 21'h10000;
    localparam logic [20:0] REPL_CP        = 21'h00FFFD;

    // encoded code point, up to four bytes, first byte at index 0
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } t_enc;

    // one queued job: all bytes one input word causes
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                len;
        logic                      last;
    } t_job;

    function automatic t_enc encode_cp(input logic [20:0] cp);
        t_enc e;
        e = '0;
        if (cp <= 21'h7F) begin
            e.bytes[0] = cp[7:0];
            e.len      = 3'd1;
        end else if (cp <= 21'h7FF) begin
            e.bytes[0] = {3'b110, cp[10:6]};
            e.bytes[1] = {2'b10, cp[5:0]};
            e.len      = 3'd2;
        end else if (cp <= 21'hFFFF) begin
            e.bytes[0] = {4'b1110, cp[15:12]};
            e.bytes[1] = {2'b10, cp[11:6]};
            e.bytes[2] = {2'b10, cp[5:0]};
            e.len      = 3'd3;
        end else begin
            e.bytes[0] = {5'b11110, cp[20:18]};
            e.bytes[1] = {2'b10, cp[17:12]};
            e.bytes[2] = {2'b10, cp[11:6]};
            e.bytes[3] = {2'b10, cp[5:0]};
            e.len      = 3'd4;
        end
        return e;
    endfunction

endpackage
`default_nettype wire

[design/utf16_to_utf8_transcoder.sv]
// UTF-16 to UTF-8 transcoder. Each input word is one UTF-16 code unit with a
// last-of-string flag; each output word is one UTF-8 byte with flags for the
// last byte of that unit's run, the last byte of the string, and whether the
// byte's position in the string lies below the capacity register. A high
// surrogate is held for the next unit; lone surrogates become U+FFFD. The
// front end classifies and encodes a code unit combinationally, pushes its
// bytes (one to six) into a small job queue; the back end drains that queue
// one byte per cycle, while the output is not stalled, into a registered
// output. A unit yields usually one to three bytes, up to six; a newly held
// high surrogate adds no bytes of its own. Input accepts in back-to-back
// cycles while the queue (P_QUEUE_DEPTH jobs) has room. Write the capacity
// only while no string is in flight.
`default_nettype none
module utf16_to_utf8_transcoder #(
    parameter int P_QUEUE_DEPTH = u16u8_pkg::QUEUE_DEPTH
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_last_unit,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_utf8_byte,
    output logic             o_run_last,
    output logic             o_string_last,
    output logic             o_within_capacity,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [31:0] i_cfg_wr_data
);
    import u16u8_pkg::*;

    logic [31:0] r_capacity;
    t_job        push_job, head_job;
    logic        push, pop, q_full, q_empty;

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= '0;
        end else if (i_cfg_wr_en) begin
            r_capacity <= i_cfg_wr_data;
        end
    end

    u16u8_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_code_unit  (i_code_unit),
        .i_last_unit  (i_last_unit),
        .i_queue_full (q_full),
        .o_in_stall   (o_in_stall),
        .o_push       (push),
        .o_job        (push_job)
    );

    u16u8_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    u16u8_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (head_job),
        .i_empty           (q_empty),
        .i_capacity        (r_capacity),
        .o_pop             (pop),
        .i_out_stall       (i_out_stall),
        .o_out_valid       (o_out_valid),
        .o_utf8_byte       (o_utf8_byte),
        .o_run_last        (o_run_last),
        .o_string_last     (o_string_last),
        .o_within_capacity (o_within_capacity)
    );

endmodule
`default_nettype wire

[design/u16u8_front.sv]
`default_nettype none
module u16u8_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire logic [15:0]   i_code_unit,
    input  wire logic          i_last_unit,
    input  wire logic          i_queue_full,
    output logic               o_in_stall,
    output logic               o_push,
    output u16u8_pkg::t_job    o_job
);
    import u16u8_pkg::*;

    logic        r_pending, n_pending;
    logic [9:0]  r_high_bits, n_high_bits;
    logic        is_high, is_low, pair, pre_repl, main_vld, accept;
    logic [20:0] main_cp;
    t_enc        main_enc, repl_enc;

    // classify the incoming word
    assign is_high  = (i_code_unit[15:10] == HIGH_SURR_BASE[15:10]);
    assign is_low   = (i_code_unit[15:10] == LOW_SURR_BASE[15:10]);
    assign pair     = r_pending && is_low;
    assign pre_repl = r_pending && !is_low;

    always_comb begin
        main_vld = 1'b1;
        main_cp  = {5'd0, i_code_unit};
        if (pair) begin
            main_cp = {1'b0, r_high_bits, i_code_unit[9:0]} + SUPP_BASE;
        end else if (is_high) begin
            main_vld = i_last_unit;
            main_cp  = REPL_CP;
        end else if (is_low) begin
            main_cp = REPL_CP;
        end
    end

    assign main_enc = encode_cp(main_cp);
    assign repl_enc = encode_cp(REPL_CP);

    // assemble the byte list for the queue
    always_comb begin
        o_job      = '0;
        o_job.last = i_last_unit;
        if (pre_repl) begin
            o_job.bytes[0] = repl_enc.bytes[0];
            o_job.bytes[1] = repl_enc.bytes[1];
            o_job.bytes[2] = repl_enc.bytes[2];
            o_job.bytes[3] = main_enc.bytes[0];
            o_job.bytes[4] = main_enc.bytes[1];
            o_job.bytes[5] = main_enc.bytes[2];
        end else begin
            o_job.bytes[0] = main_enc.bytes[0];
            o_job.bytes[1] = main_enc.bytes[1];
            o_job.bytes[2] = main_enc.bytes[2];
            o_job.bytes[3] = main_enc.bytes[3];
        end
        o_job.len = (pre_repl ? 3'd3 : 3'd0) + (main_vld ? main_enc.len : 3'd0);
    end

    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign o_push     = accept && (o_job.len != 3'd0);

    // pending high surrogate
    always_comb begin
        n_pending   = r_pending;
        n_high_bits = r_high_bits;
        if (accept) begin
            if (i_last_unit) begin
                n_pending   = 1'b0;
                n_high_bits = '0;
            end else if (is_high && !pair) begin
                n_pending   = 1'b1;
                n_high_bits = i_code_unit[9:0];
            end else begin
                n_pending   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending   <= 1'b0;
            r_high_bits <= '0;
        end else begin
            r_pending   <= n_pending;
            r_high_bits <= n_high_bits;
        end
    end

endmodule
`default_nettype wire

[design/u16u8_queue.sv]
`default_nettype none
module u16u8_queue #(
    parameter int P_DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire u16u8_pkg::t_job i_job,
    input  wire logic          i_pop,
    output u16u8_pkg::t_job    o_head,
    output logic               o_full,
    output logic               o_empty
);
    import u16u8_pkg::*;

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(P_DEPTH - 1);

    t_job             r_mem [P_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(P_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

[design/u16u8_back.sv]
`default_nettype none
module u16u8_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire u16u8_pkg::t_job i_head,
    input  wire logic          i_empty,
    input  wire logic [31:0]   i_capacity,
    output logic               o_pop,
    input  wire logic          i_out_stall,
    output logic               o_out_valid,
    output logic [7:0]         o_utf8_byte,
    output logic               o_run_last,
    output logic               o_string_last,
    output logic               o_within_capacity
);
    import u16u8_pkg::*;

    logic [2:0]  r_idx;
    logic [31:0] r_pos;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_run_last, r_str_last, r_within;
    logic        load, run_end, str_end;

    // one byte per cycle into the output register unless stalled or empty
    assign load    = !i_empty && (!r_valid || !i_out_stall);
    assign run_end = (r_idx == 3'(i_head.len - 3'd1));
    assign str_end = run_end && i_head.last;
    assign o_pop   = load && run_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
            r_pos   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= run_end ? 3'd0 : r_idx + 3'd1;
                if (str_end) begin
                    r_pos <= '0;
                end else if (r_pos != '1) begin
                    r_pos <= r_pos + 32'd1;
                end
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte     <= i_head.bytes[r_idx];
            r_run_last <= run_end;
            r_str_last <= str_end;
            r_within   <= (r_pos < i_capacity);
        end
    end

    assign o_out_valid       = r_valid;
    assign o_utf8_byte       = r_byte;
    assign o_run_last        = r_run_last;
    assign o_string_last     = r_str_last;
    assign o_within_capacity = r_within;

endmodule
`default_nettype wire

[design/u16u8_checker.sv]
`default_nettype none
`include "utf16_to_utf8_transcoder_macros.svh"
module u16u8_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        o_in_stall,
    input  wire logic [15:0] i_code_unit,
    input  wire logic        i_last_unit,
    input  wire logic        o_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [7:0]  o_utf8_byte,
    input  wire logic        o_run_last,
    input  wire logic        o_string_last,
    input  wire logic        o_within_capacity
);

    logic [16:0] in_word;
    logic [10:0] out_word;

    assign in_word  = {i_code_unit, i_last_unit};
    assign out_word = {o_utf8_byte, o_run_last, o_string_last, o_within_capacity};

    // a stalled input word holds its payload
    `U16U8_ASSERT_HOLD(a_in_hold, i_in_valid, o_in_stall, in_word, "input word moved")

    // a stalled output word holds its byte and flags
    `U16U8_ASSERT_HOLD(a_out_hold, o_out_valid, i_out_stall, out_word, "output word moved")

    // end of string always closes a run
    `U16U8_ASSERT(a_str_run, (o_out_valid && o_string_last) |-> o_run_last, "string end mid run")

    // bytes before the end of a run are lead or continuation bytes
    `U16U8_ASSERT(a_mid_run, (o_out_valid && !o_run_last) |-> o_utf8_byte[7], "ascii byte mid run")

    // no byte of the form 11111xxx is ever produced
    `U16U8_ASSERT(a_no_ff, o_out_valid |-> (o_utf8_byte[7:3] != 5'b11111), "illegal utf-8 byte")

endmodule

bind utf16_to_utf8_transcoder u16u8_checker u_chk (.*);
`default_nettype wire

[tb/utf16_to_utf8_transcoder_tb.sv]
`default_nettype none
module utf16_to_utf8_transcoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // utf-16 classification bounds and fixed code points
    localparam logic [15:0] HI_FIRST   = 16'hD800;
    localparam logic [15:0] HI_LAST    = 16'hDBFF;
    localparam logic [15:0] LO_FIRST   = 16'hDC00;
    localparam logic [15:0] LO_LAST    = 16'hDFFF;
    localparam logic [20:0] SUPP_FIRST = 21'h10000;
    localparam logic [20:0] REPLACE_CP = 21'h00FFFD;
    localparam logic [31:0] POS_TOP    = 32'hFFFF_FFFF;
    localparam int          SETTLE_CYC = 8;
    localparam int          MAX_SHOWN  = 10;

    // one expected output word
    typedef struct packed {
        logic [7:0] octet;
        logic       run_last;
        logic       string_last;
        logic       within_cap;
    } t_utf8_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [15:0] i_code_unit;
    logic        i_last_unit;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_utf8_byte;
    logic        o_run_last;
    logic        o_string_last;
    logic        o_within_capacity;
    logic        i_cfg_wr_en;
    logic [31:0] i_cfg_wr_data;

    // transcoder model state
    logic        hi_held;
    logic [9:0]  hi_bits;
    logic [31:0] str_pos;
    logic [31:0] capacity;
    t_utf8_word  pending_bytes[$];

    int src_idle_pct  = 18;
    int sink_idle_pct = 18;
    int units_sent    = 0;
    int strings_sent  = 0;
    int bytes_checked = 0;
    int errors        = 0;

    utf16_to_utf8_transcoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_code_unit      (i_code_unit),
        .i_last_unit      (i_last_unit),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_utf8_byte      (o_utf8_byte),
        .o_run_last       (o_run_last),
        .o_string_last    (o_string_last),
        .o_within_capacity(o_within_capacity),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // number one byte of the string and flag it against the capacity
    function automatic void emit_octet(input logic [7:0] v);
        t_utf8_word w;
        w.octet       = v;
        w.run_last    = 1'b0;
        w.string_last = 1'b0;
        w.within_cap  = (str_pos < capacity);
        if (str_pos != POS_TOP)
            str_pos = str_pos + 32'd1;
        pending_bytes.insert(pending_bytes.size(), w);
    endfunction

    function automatic void emit_code_point(input logic [20:0] cp);
        if (cp <= 21'h7F) begin
            emit_octet(cp[7:0]);
        end else if (cp <= 21'h7FF) begin
            emit_octet(8'hC0 | {3'b0, cp[10:6]});
            emit_octet(8'h80 | {2'b0, cp[5:0]});
        end else if (cp <= 21'hFFFF) begin
            emit_octet(8'hE0 | {4'b0, cp[15:12]});
            emit_octet(8'h80 | {2'b0, cp[11:6]});
            emit_octet(8'h80 | {2'b0, cp[5:0]});
        end else begin
            emit_octet(8'hF0 | {5'b0, cp[20:18]});
            emit_octet(8'h80 | {2'b0, cp[17:12]});
            emit_octet(8'h80 | {2'b0, cp[11:6]});
            emit_octet(8'h80 | {2'b0, cp[5:0]});
        end
    endfunction

    // expected bytes for one accepted code unit
    function automatic void encode_unit(input logic [15:0] cu, input logic lst);
        int   first_idx;
        logic is_hi;
        logic is_lo;
        first_idx = pending_bytes.size();
        is_hi = (cu >= HI_FIRST) && (cu <= HI_LAST);
        is_lo = (cu >= LO_FIRST) && (cu <= LO_LAST);
        if (hi_held && is_lo) begin
            hi_held = 1'b0;
            emit_code_point(SUPP_FIRST + {1'b0, hi_bits, 10'b0} + {11'b0, cu[9:0]});
        end else begin
            // a held high surrogate with no partner is replaced first
            if (hi_held) begin
                hi_held = 1'b0;
                emit_code_point(REPLACE_CP);
            end
            if (is_hi) begin
                if (lst) begin
                    emit_code_point(REPLACE_CP);
                end else begin
                    hi_held = 1'b1;
                    hi_bits = cu[9:0];
                end
            end else if (is_lo) begin
                emit_code_point(REPLACE_CP);
            end else begin
                emit_code_point({5'b0, cu});
            end
        end
        if (pending_bytes.size() > first_idx) begin
            pending_bytes[pending_bytes.size()-1].run_last    = 1'b1;
            pending_bytes[pending_bytes.size()-1].string_last = lst;
        end
        // end of string clears the counter and any held unit
        if (lst) begin
            str_pos = '0;
            hi_held = 1'b0;
            hi_bits = '0;
        end
    endfunction

    // send one code unit; valid stays high until the caller sends again or drains
    task automatic send_unit(input logic [15:0] cu, input logic lst);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_code_unit <= cu;
        i_last_unit <= lst;
        do @(posedge i_clk); while (o_in_stall);
        encode_unit(cu, lst);
        units_sent++;
        if (lst)
            strings_sent++;
    endtask

    // stop sending and wait for every expected word plus a settle time
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_capacity(input logic [31:0] v);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        capacity = v;
        i_cfg_wr_en <= 1'b0;
    endtask

    // output side back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= i_rst_n && ($urandom_range(0, 99) < sink_idle_pct);
    end

    // compare each accepted word with the oldest expected one
    always @(posedge i_clk) begin
        t_utf8_word got;
        t_utf8_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_utf8_byte, o_run_last, o_string_last, o_within_capacity};
            bytes_checked++;
            if (pending_bytes.size() == 0) begin
                errors++;
                if (errors <= MAX_SHOWN)
                    $display("%0t unexpected word: byte %02h run %b str %b cap %b",
                             $realtime, got.octet, got.run_last, got.string_last,
                             got.within_cap);
            end else begin
                want = pending_bytes.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("%0t word mismatch: exp %02h/%b/%b/%b got %02h/%b/%b/%b",
                                 $realtime, want.octet, want.run_last, want.string_last,
                                 want.within_cap, got.octet, got.run_last,
                                 got.string_last, got.within_cap);
                end
            end
        end
    end

    // encoding length boundaries
    task automatic test_basic_widths;
        set_capacity(POS_TOP);
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
    endtask

    // valid pairs at both ends of the supplementary range
    task automatic test_surrogate_pairs;
        set_capacity(32'd2);
        send_unit(HI_FIRST, 1'b0);
        send_unit(LO_FIRST, 1'b0);
        send_unit(HI_LAST, 1'b0);
        send_unit(LO_LAST, 1'b1);
    endtask

    // lone surrogates, held high followed by other units, high at string end
    task automatic test_broken_surrogates;
        send_unit(16'hDC00, 1'b0);
        send_unit(16'hD912, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hD800, 1'b0);
        send_unit(16'h4E2D, 1'b0);
        send_unit(16'hDA00, 1'b0);
        send_unit(16'hDB00, 1'b1);
        send_unit(16'hDFFF, 1'b1);
    endtask

    // zero capacity and a capacity change while a high surrogate is held
    task automatic test_capacity_flag;
        set_capacity(32'd0);
        send_unit(16'h00E9, 1'b0);
        send_unit(16'h20AC, 1'b1);
        set_capacity(32'd1);
        send_unit(16'h0041, 1'b0);
        send_unit(16'hD83D, 1'b0);
        set_capacity(32'd3);
        send_unit(16'hDE00, 1'b1);
    endtask

    // mostly well-formed strings with random content, some broken units
    task automatic send_random_strings(input int n_units);
        int          target;
        int          len;
        int          kind;
        logic        fin;
        logic [15:0] cu;
        target = units_sent + n_units;
        while (units_sent < target) begin
            len = $urandom_range(1, 8);
            for (int k = 0; k < len; k++) begin
                fin  = (k == len - 1);
                kind = $urandom_range(0, 99);
                if (kind < 20) begin
                    send_unit(16'($urandom_range(0, 16'h7F)), fin);
                end else if (kind < 40) begin
                    send_unit(16'($urandom_range(16'h80, 16'h7FF)), fin);
                end else if (kind < 60) begin
                    if ($urandom_range(0, 1))
                        cu = 16'($urandom_range(16'h800, 16'hD7FF));
                    else
                        cu = 16'($urandom_range(16'hE000, 16'hFFFF));
                    send_unit(cu, fin);
                end else if (kind < 85) begin
                    send_unit(16'($urandom_range(HI_FIRST, HI_LAST)), 1'b0);
                    send_unit(16'($urandom_range(LO_FIRST, LO_LAST)), fin);
                end else if (kind < 90) begin
                    send_unit(16'($urandom_range(HI_FIRST, HI_LAST)), fin);
                end else if (kind < 95) begin
                    send_unit(16'($urandom_range(LO_FIRST, LO_LAST)), fin);
                end else begin
                    send_unit(16'($urandom_range(0, 16'hFFFF)), fin);
                end
            end
        end
    endtask

    task automatic test_random_strings;
        set_capacity(32'($urandom_range(1, 10)));
        send_random_strings(30);
        set_capacity(32'd0);
        send_random_strings(30);
        // long stretch with no idling on either side
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_capacity(POS_TOP);
        send_random_strings(30);
        src_idle_pct  = 18;
        sink_idle_pct = 18;
        set_capacity($urandom());
        send_random_strings(15);
        set_capacity(32'($urandom_range(0, 24)));
        send_random_strings(15);
    endtask

    initial begin
        hi_held  = 1'b0;
        hi_bits  = '0;
        str_pos  = '0;
        capacity = '0;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_code_unit   <= '0;
        i_last_unit   <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_widths();
        test_surrogate_pairs();
        test_broken_surrogates();
        test_capacity_flag();
        test_random_strings();
        drain();

        $display("covered %0d code units in %0d strings, %0d output bytes checked",
                 units_sent, strings_sent, bytes_checked);
        $display("capacity settings from zero to all ones, with and without back-pressure");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // run limit
    initial begin
        #4_000_000;
        $display("timeout with %0d bytes still expected", pending_bytes.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
